FILE: rtl/encoder_frame_deframer_top_assert.svh
// Assertion macros shared by the deframer RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef ENCODER_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define ENCODER_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define EFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/efd_pkg.sv
// Package for the frame deframer: frame geometry, sync bytes, result type.
// No dependencies.
`timescale 1ns / 1ps

package efd_pkg;

    localparam int FRAME_LEN = 20;
    localparam int WIN_DEPTH = FRAME_LEN - 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

    localparam logic [7:0] SYNC_A0 = 8'hBA;
    localparam logic [7:0] SYNC_A1 = 8'hAB;
    localparam logic [7:0] SYNC_B0 = 8'hCD;
    localparam logic [7:0] SYNC_B1 = 8'hDC;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] count_t;

    // first_count in the lowest bits, fourth_count in the highest.
    typedef struct packed {
        count_t fourth_count;
        count_t third_count;
        count_t second_count;
        count_t first_count;
    } frame_counts_t;

    // Load request from the window logic into the output stage.
    typedef struct packed {
        logic          valid;
        frame_counts_t counts;
    } out_load_t;

endpackage

FILE: rtl/efd_cell.sv
// One byte cell of the deframer window shift chain.
// Depends on efd_pkg.
`timescale 1ns / 1ps

module efd_cell
    import efd_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  byte_t data_in,
    output byte_t data_out
);

    byte_t data_reg;
    byte_t data_next;

    always_comb
    begin
        data_next = shift ? data_in : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

FILE: rtl/efd_out_reg.sv
// Output register of the deframer: holds one result word until taken.
// Depends on efd_pkg.
`timescale 1ns / 1ps

module efd_out_reg
    import efd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  out_load_t     load,
    output logic          room,
    output logic          m_tvalid,
    input  logic          m_tready,
    output frame_counts_t m_counts
);

    logic          valid_reg;
    logic          valid_next;
    frame_counts_t counts_reg;

    // Free for a new word when empty or when the held word leaves this cycle.
    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load.valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            counts_reg <= load.counts;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_counts = counts_reg;

endmodule

FILE: rtl/encoder_frame_deframer_top.sv
// Frame deframer: 19-cell byte shift chain plus incoming byte form a 20-byte frame.
// A matching frame's result is registered and is valid the cycle after its last byte is taken.
// Throughput: one byte per cycle; s_tready drops only while a result waits on m_tready.
// Rate is set by the shift chain, which shifts on every accepted byte, and the one-entry output register.
// Reset (rst_n, async low) clears fill count and output valid; window bytes are not reset.
`timescale 1ns / 1ps

module encoder_frame_deframer_top
    import efd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] first_count, [63:32] second_count,
                                    // [95:64] third_count, [127:96] fourth_count
);

    `include "encoder_frame_deframer_top_assert.svh"

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic          accept;
    logic          full;
    logic          match;
    logic          room;
    byte_t         win [WIN_DEPTH];
    out_load_t     load;
    frame_counts_t counts;
    frame_counts_t out_counts;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_reg == FILL_FULL);

    // Cell 0 holds the oldest byte; new bytes enter at the far end.
    genvar g;
    generate
        for (g = 0; g < WIN_DEPTH; g++)
        begin : g_cell
            byte_t cell_in;
            if (g == WIN_DEPTH - 1)
            begin : g_tail
                assign cell_in = s_tdata;
            end
            else
            begin : g_body
                assign cell_in = win[g + 1];
            end
            efd_cell u_cell (
                .clk      (clk),
                .shift    (accept),
                .data_in  (cell_in),
                .data_out (win[g])
            );
        end
    endgenerate

    assign match = full && (win[0] == SYNC_A0) && (win[1] == SYNC_A1)
                        && (win[10] == SYNC_B0) && (win[11] == SYNC_B1);

    always_comb
    begin
        counts.first_count  = {win[2], win[3], win[4], win[5]};
        counts.second_count = {win[6], win[7], win[8], win[9]};
        counts.third_count  = {win[12], win[13], win[14], win[15]};
        counts.fourth_count = {win[16], win[17], win[18], s_tdata};
    end

    assign load.valid  = accept && match;
    assign load.counts = counts;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (match)
            begin
                fill_next = '0;
            end
            else if (!full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    efd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_counts (out_counts)
    );

    assign m_tdata = out_counts;

    `EFD_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= FILL_FULL,
        "fill count beyond window depth")
    `EFD_ASSERT_NOW(a_match_needs_full, match, full,
        "sync match on a partly filled window")
    `EFD_ASSERT_NEXT(a_match_emits, accept && match, m_tvalid && fill_reg == '0,
        "matched frame did not produce a word or clear the window")
    `EFD_ASSERT_NEXT(a_fill_grows, accept && !full,
        fill_reg == $past(fill_reg) + FILL_W'(1),
        "fill count did not advance on a byte")

endmodule

FILE: dv/tb_encoder_frame_deframer_top.sv
// Self-checking testbench for the frame deframer: byte stream in, four counts out.
// Depends on efd_pkg and encoder_frame_deframer_top; a built-in frame predictor checks results.
`timescale 1ns / 1ps

module tb_encoder_frame_deframer_top;
    import efd_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SEED_ROWS    = 21;

    typedef struct packed {
        byte_t         data;
        logic          typed;
        frame_counts_t counts;
    } seed_row_t;

    logic         clk;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [127:0] m_tdata;

    // Shift chain model of the block and the counts still owed by it.
    byte_t         hunt_window [WIN_DEPTH];
    int unsigned   hunt_fill = 0;
    frame_counts_t pending_counts [$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;

    // Leading stray sync byte forces one slip, then a frame with extreme counts.
    seed_row_t seed_rows [SEED_ROWS] = '{
        '{8'hBA, 1'b0, '0}, '{8'hBA, 1'b0, '0}, '{8'hAB, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hCD, 1'b0, '0},
        '{8'hDC, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h12, 1'b0, '0},
        '{8'h34, 1'b0, '0}, '{8'h56, 1'b0, '0},
        '{8'h78, 1'b1, 128'h12345678_80000001_00000000_FFFFFFFF}
    };

    encoder_frame_deframer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit quiet_phase();
        return ((($time / 10) / 2500) % 4) == 1;
    endfunction

    // Advance the window by one byte; return 1 with the counts when a frame locks.
    function automatic bit deframe_byte(input byte_t b, output frame_counts_t counts);
        byte_t f [FRAME_LEN];
        counts = '0;
        if (hunt_fill < WIN_DEPTH)
        begin
            hunt_window[hunt_fill] = b;
            hunt_fill++;
            return 1'b0;
        end
        for (int i = 0; i < WIN_DEPTH; i++)
            f[i] = hunt_window[i];
        f[WIN_DEPTH] = b;
        if (f[0] == SYNC_A0 && f[1] == SYNC_A1 && f[10] == SYNC_B0 && f[11] == SYNC_B1)
        begin
            counts.first_count  = {f[2],  f[3],  f[4],  f[5]};
            counts.second_count = {f[6],  f[7],  f[8],  f[9]};
            counts.third_count  = {f[12], f[13], f[14], f[15]};
            counts.fourth_count = {f[16], f[17], f[18], f[19]};
            hunt_fill = 0;
            return 1'b1;
        end
        for (int i = 0; i < WIN_DEPTH; i++)
            hunt_window[i] = f[i + 1];
        return 1'b0;
    endfunction

    // Offer one byte after a random gap, hold until taken, then predict.
    task automatic push_byte(input byte_t b, input bit typed, input frame_counts_t typed_counts);
        int unsigned   gap;
        int unsigned   r;
        bit            hit;
        frame_counts_t pred;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!quiet_phase())
        begin
            if (r >= 96)
                gap = $urandom_range(8, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        hit = deframe_byte(b, pred);
        if (typed)
            pending_counts.push_back(typed_counts);
        else if (hit)
            pending_counts.push_back(pred);
    endtask

    // Send a frame with random counts; break one sync byte or cut it short on request.
    task automatic send_frame(input int unsigned broken_pos, input int unsigned length);
        byte_t       f [FRAME_LEN];
        int unsigned base;
        int unsigned r;
        for (int i = 0; i < FRAME_LEN; i++)
            f[i] = byte_t'($urandom);
        for (int w = 0; w < 4; w++)
        begin
            base = (w < 2) ? 2 + 4 * w : 4 + 4 * w;
            r = $urandom_range(0, 7);
            for (int k = 0; k < 4; k++)
            begin
                if (r == 0)
                    f[base + k] = 8'h00;
                else if (r == 1)
                    f[base + k] = 8'hFF;
            end
        end
        f[0]  = SYNC_A0;
        f[1]  = SYNC_A1;
        f[10] = SYNC_B0;
        f[11] = SYNC_B1;
        if (broken_pos < FRAME_LEN)
            f[broken_pos] = f[broken_pos] ^ byte_t'($urandom_range(1, 255));
        for (int i = 0; i < length; i++)
            push_byte(f[i], 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int unsigned r;
        int unsigned pos;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < SEED_ROWS; i++)
            push_byte(seed_rows[i].data, seed_rows[i].typed, seed_rows[i].counts);
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                send_frame(FRAME_LEN, FRAME_LEN);
            else if (r < 80)
            begin
                pos = $urandom_range(0, 3);
                pos = (pos < 2) ? pos : pos + 8;
                send_frame(pos, FRAME_LEN);
            end
            else if (r < 90)
                send_frame(FRAME_LEN, $urandom_range(1, FRAME_LEN - 1));
            else
                repeat ($urandom_range(1, 6)) push_byte(byte_t'($urandom), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial
    begin : result_sink
        int unsigned hold;
        int unsigned seen;
        int unsigned r;
        bit          pressed;
        hold    = 0;
        seen    = 0;
        pressed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                seen++;
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!pressed && seen >= 12)
            begin
                pressed = 1'b1;
                hold    = 400;
                m_tready <= 1'b0;
            end
            else if (quiet_phase())
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        logic [3:0][31:0] got;
        logic [3:0][31:0] want;
        string            lbl;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_counts.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: got %h", got);
                mismatches++;
            end
            else
            begin
                want = pending_counts.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        case (i)
                            0: lbl = "first_count";
                            1: lbl = "second_count";
                            2: lbl = "third_count";
                            default: lbl = "fourth_count";
                        endcase
                        if (mismatches < 10)
                            $display("%s mismatch: expected %h, got %h", lbl, want[i], got[i]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

endmodule
